>>> rtl/tsd_pkg.sv
// Package for the length-type-value stream deframer.
// Holds the result record and the header constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

  localparam int unsigned HdrBytes = 8;
  localparam int unsigned HdrCntW  = 3;
  localparam logic [HdrCntW-1:0] HdrLast     = 3'd7;
  localparam logic [HdrCntW-1:0] HdrTypeBase = 3'd4;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEmpty   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] type_word;
    logic [31:0] msg_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/tsd_if.sv
// Stream channel interfaces for the deframer: raw byte input and result output.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface tsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tsd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] type_word;
  logic [31:0] msg_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output type_word, output msg_length,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input type_word, input msg_length,
                  input payload_byte, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/tsd_parser.sv
// Header/payload tracker of the deframer: assembles length and type, counts payload.
// Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  output logic                 res_valid_o,
  output tsd_pkg::result_t     res_o
);

  logic                         in_payload_q, in_payload_d;
  logic [tsd_pkg::HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0]                  len_q, len_d;
  logic [31:0]                  type_q, type_d;
  logic [31:0]                  remaining_q, remaining_d;
  logic                         fin;

  assign fin = (remaining_q <= 32'd1);

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    len_d        = len_q;
    type_d       = type_q;
    remaining_d  = remaining_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (accept_i) begin
      if (in_payload_q) begin
        res_valid_o        = 1'b1;
        res_o.kind         = tsd_pkg::KindPayload;
        res_o.payload_byte = data_byte_i;
        res_o.last         = fin;
        if (fin) begin
          remaining_d  = '0;
          in_payload_d = 1'b0;
          hdr_cnt_d    = '0;
        end else begin
          remaining_d = remaining_q - 32'd1;
        end
      end else begin
        // first byte of each word clears the rest of it
        if (hdr_cnt_q < tsd_pkg::HdrTypeBase) begin
          if (hdr_cnt_q == '0) len_d = '0;
          len_d[{hdr_cnt_q[1:0], 3'b000} +: 8] = data_byte_i;
        end else begin
          if (hdr_cnt_q == tsd_pkg::HdrTypeBase) type_d = '0;
          type_d[{hdr_cnt_q[1:0], 3'b000} +: 8] = data_byte_i;
        end

        if (hdr_cnt_q == tsd_pkg::HdrLast) begin
          hdr_cnt_d = '0;
          if (len_d == '0) begin
            res_valid_o = 1'b1;
            res_o.kind  = tsd_pkg::KindEmpty;
            res_o.last  = 1'b1;
          end else begin
            remaining_d  = len_d;
            in_payload_d = 1'b1;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q + 1'b1;
        end
      end
    end

    res_o.type_word  = type_d;
    res_o.msg_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      len_q        <= '0;
      type_q       <= '0;
      remaining_q  <= '0;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      len_q        <= len_d;
      type_q       <= type_d;
      remaining_q  <= remaining_d;
    end
  end

`ifndef SYNTHESIS
  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (remaining_q != '0))
    else $error("payload phase with nothing remaining");

  a_enter_payload_at_hdr_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_payload_q) |-> (hdr_cnt_q == '0) && (remaining_q == len_q))
    else $error("payload phase entered with stale header state");
`endif

endmodule

`default_nettype wire

>>> rtl/tsd_out_buf.sv
// Result register plus skid entry; decouples the sender from a stalling receiver.
// Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tsd_pkg::result_t push_data_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output tsd_pkg::result_t      out_data_o
);

  logic             main_v_q, main_v_d;
  logic             skid_v_q, skid_v_d;
  tsd_pkg::result_t main_q, main_d;
  tsd_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop         = main_v_q && out_ready_i;
  assign space_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;

    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = 1'b0;
      end
    end

    if (push_i) begin
      if (!main_v_d) begin
        main_d   = push_data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held with empty result register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q)
    else $error("result pushed into a full buffer");
`endif

endmodule

`default_nettype wire

>>> rtl/tlv_stream_deframer.sv
// Length-type-value stream deframer, top level.
// Uses tsd_pkg, tsd_if, tsd_parser and tsd_out_buf.
//
// byte_i carries the raw stream, one byte per transfer. Each message is an
// 8-byte header (32-bit little-endian length, then 32-bit little-endian type)
// followed by that many payload bytes. res_o gives one result per payload
// byte, tagged with type and length, with last set on the final byte. A
// zero-length message gives one result with kind set and last set on its
// eighth header byte. Header bytes otherwise give nothing.
//
// One byte is taken every cycle while the skid entry is free. The result that a
// byte causes is formed combinationally and registered in the result register,
// or in the skid entry while that register is held. The header counter and the
// payload down counter update in the cycle of the transfer, ahead of the buffer.
// When res_o stalls, byte_i keeps taking bytes until the skid entry fills,
// then drops ready until the receiver takes a result; nothing is lost.
// Reset puts the block in the header phase with an empty output buffer.
`timescale 1ns / 1ps
`default_nettype none

module tlv_stream_deframer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tsd_byte_if.sink  byte_i,
  tsd_res_if.source res_o
);

  logic             accept;
  logic             res_valid;
  logic             space;
  tsd_pkg::result_t res;
  tsd_pkg::result_t out_data;

  assign byte_i.ready = space;
  assign accept       = byte_i.valid && space;

  tsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (byte_i.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (out_data)
  );

  assign res_o.kind         = out_data.kind;
  assign res_o.type_word    = out_data.type_word;
  assign res_o.msg_length   = out_data.msg_length;
  assign res_o.payload_byte = out_data.payload_byte;
  assign res_o.last         = out_data.last;

endmodule

`default_nettype wire
